// ----- sv/sti_pkg.sv -----
`timescale 1ns / 1ps

package sti_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LH_W        = IDX_W + 2;
	localparam int KEY_W       = 32;
	localparam int LEN_W       = 11;
	localparam int LOAD_IDX_W  = 10;
	localparam int POS_W       = 10;
	localparam int PROD_W      = KEY_W + IDX_W;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [LH_W-1:0]  bound_t;
	typedef logic [PROD_W-1:0]       prod_t;

endpackage

// ----- sv/sti_if.sv -----
`timescale 1ns / 1ps

interface sti_in_if;
	import sti_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  func;
	key_t                  key;
	logic [LOAD_IDX_W-1:0] load_index;

	modport source (output valid, func, key, load_index, input ready);
	modport sink   (input valid, func, key, load_index, output ready);
endinterface

interface sti_out_if;
	import sti_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink   (input valid, found, position, output ready);
endinterface

interface sti_cfg_if;
	import sti_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] list_length;

	modport source (output valid, list_length, input ready);
	modport sink   (input valid, list_length, output ready);
endinterface

// ----- sv/sti_div.sv -----
`timescale 1ns / 1ps

module sti_div
	import sti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  prod_t                 num,
	input  logic [KEY_W-1:0]      den,
	output logic                  done,
	output idx_t                  quo
);

	localparam int CNT_W = $clog2(IDX_W + 1);

	prod_t            rem_q;
	prod_t            dsh_q;
	idx_t             quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [PROD_W:0]  diff;
	logic             ge;

	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge   = !diff[PROD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_W'(1));
			if (start) begin
				rem_q <= num;
				dsh_q <= PROD_W'(den) << (IDX_W - 1);
				quo_q <= '0;
				cnt_q <= CNT_W'(IDX_W);
			end else if (cnt_q != '0) begin
				if (ge) begin
					rem_q <= diff[PROD_W-1:0];
				end
				quo_q  <= {quo_q[IDX_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- sv/sorted_table_interpolation_search.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Transfer
// in_ch     in   func, key[31:0], load_index[9:0] valid & ready
// out_ch    out  found, position[9:0]            valid & ready
// cfg_ch    in   list_length[10:0]               valid & ready (ready tied high)
//
// A load writes the table when it is accepted. A search has an accept step and a result
// step, and each probe that divides runs these steps in order: read and check the bound
// keys, one multiply, the divider (start, 10 quotient bits, handoff), one probe read, the
// compare and the loop test. A probe with equal bound keys skips the multiply and divider.
// The table has one read port; every probe re-reads both bound keys.
// Reset clears control and list_length; table contents are undefined until loaded.
// Input stalls while a search runs; a finished result waits in the output register.

module sorted_table_interpolation_search
	import sti_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sti_in_if.sink    in_ch,
	sti_out_if.source out_ch,
	sti_cfg_if.sink   cfg_ch
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RLO,
		S_RHI,
		S_CHK,
		S_MUL,
		S_DIV,
		S_RP,
		S_CMP,
		S_LOOP,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	key_t              key_q;
	key_t              vlo_q;
	bound_t            lo_q;
	bound_t            hi_q;
	idx_t              probe_q;
	logic [KEY_W-1:0]  diff_q;
	logic [KEY_W-1:0]  den_q;
	idx_t              span_q;
	prod_t             prod_q;
	logic              start_q;
	logic              found_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [POS_W-1:0]  out_pos_q;

	key_t              mem [TABLE_DEPTH];
	key_t              rdata_q;
	idx_t              raddr;
	logic              we;

	logic [LH_W-1:0]   eff_len;
	bound_t            hi_init;
	logic [KEY_W:0]    sub_key;
	logic [KEY_W:0]    sub_den;
	logic              div_done;
	idx_t              div_quo;

	sti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		if ({21'b0, len_q} > 32'(TABLE_DEPTH)) begin
			eff_len = LH_W'(TABLE_DEPTH);
		end else begin
			eff_len = LH_W'(len_q);
		end
		hi_init = $signed(eff_len) - bound_t'(1);
		sub_key = {key_q[KEY_W-1], key_q} - {vlo_q[KEY_W-1], vlo_q};
		sub_den = {rdata_q[KEY_W-1], rdata_q} - {vlo_q[KEY_W-1], vlo_q};
	end

	always_comb begin
		unique case (state_q)
			S_RHI:   raddr = hi_q[IDX_W-1:0];
			S_RP:    raddr = probe_q;
			default: raddr = lo_q[IDX_W-1:0];
		endcase
	end

	assign we = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_LOAD)
		&& (32'(in_ch.load_index) < 32'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[IDX_W'(in_ch.load_index)] <= in_ch.key;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			key_q       <= '0;
			vlo_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			probe_q     <= '0;
			diff_q      <= '0;
			den_q       <= '0;
			span_q      <= '0;
			prod_q      <= '0;
			start_q     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_pos_q   <= '0;
		end else begin
			start_q <= (state_q == S_MUL);
			if (cfg_ch.valid && cfg_ch.ready) begin
				len_q <= cfg_ch.list_length;
			end
			if (out_valid_q && out_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.func == FUNC_SEARCH) begin
						key_q   <= in_ch.key;
						lo_q    <= '0;
						hi_q    <= hi_init;
						found_q <= 1'b0;
						probe_q <= '0;
						state_q <= (eff_len == '0) ? S_DONE : S_RLO;
					end
				end
				S_RLO: begin
					state_q <= S_RHI;
				end
				S_RHI: begin
					vlo_q   <= rdata_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (key_q < vlo_q || key_q > rdata_q) begin
						state_q <= S_DONE;
					end else if (rdata_q == vlo_q) begin
						probe_q <= lo_q[IDX_W-1:0];
						state_q <= S_RP;
					end else begin
						diff_q  <= sub_key[KEY_W-1:0];
						den_q   <= sub_den[KEY_W-1:0];
						span_q  <= IDX_W'(hi_q - lo_q);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(diff_q) * PROD_W'(span_q);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						probe_q <= lo_q[IDX_W-1:0] + div_quo;
						state_q <= S_RP;
					end
				end
				S_RP: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rdata_q == key_q) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (rdata_q < key_q) begin
							lo_q <= $signed({2'b00, probe_q}) + bound_t'(1);
						end else begin
							hi_q <= $signed({2'b00, probe_q}) - bound_t'(1);
						end
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					state_q <= (lo_q <= hi_q) ? S_RLO : S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= found_q;
						out_pos_q   <= found_q ? POS_W'(probe_q) : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready     = (state_q == S_IDLE);
	assign cfg_ch.ready    = 1'b1;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.found    = out_found_q;
	assign out_ch.position = out_pos_q;

endmodule
